### rtl/gnpa_pkg.sv
// Package with the sizes, payload structs and control structs of the nearest-pair assigner.
`default_nettype none

package gnpa_pkg;

    localparam int MAX_WORKERS   = 16;
    localparam int MAX_RESOURCES = 16;
    localparam int COORD_BITS    = 10;

    localparam int W_IDX_BITS   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int R_IDX_BITS   = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int W_CNT_BITS   = $clog2(MAX_WORKERS + 1);
    localparam int R_CNT_BITS   = $clog2(MAX_RESOURCES + 1);
    localparam int DIST_BITS    = COORD_BITS + 1;
    localparam int OUT_IDX_BITS = 4;
    localparam int POINT_BITS   = 2 * COORD_BITS;

    typedef enum logic [1:0] {
        OP_LOAD_WORKER   = 2'd0,
        OP_LOAD_RESOURCE = 2'd1,
        OP_RUN           = 2'd2,
        OP_NONE          = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  x_coord;
        logic [9:0]  y_coord;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  worker_index;
        logic [3:0]  resource_index;
        logic        has_resource;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } point_t;

    // One candidate pair sent into the distance pipeline.
    typedef struct packed {
        logic                  valid;
        logic [W_IDX_BITS-1:0] w;
        logic [R_IDX_BITS-1:0] r;
    } probe_t;

    // Best pair found so far in the current round.
    typedef struct packed {
        logic                  found;
        logic [W_IDX_BITS-1:0] w;
        logic [R_IDX_BITS-1:0] r;
    } best_t;

endpackage

`default_nettype wire

### rtl/greedy_nearest_pair_assigner.sv
// Top level of the greedy nearest-pair assigner: sequencer, point stores and result register.
//
// Input channel s_valid/s_ready/s_payload carries load and run items; the result
// channel m_valid/m_ready/m_payload carries one result per loaded worker after a run.
// A load worker or load resource item gives no result; a load into a full store is
// dropped. An opcode of 3 is ignored. A run scans every worker/resource pair once
// per picked pair, one pair per cycle through the point memories and the distance
// pipeline; the single read port of each point memory sets the one-pair-per-cycle
// scan rate. Results leave in worker order, with last set on the final one.
// A run with no workers gives no result and empties the resource store as well.
// s_ready is low while a run is in progress. A result waits in the output register
// while m_ready is low, and the run holds until that transfer takes place; the
// transfer of the final result need not complete before the next load is taken.
// Reset (aresetn low at a clock edge) empties both stores and drops any result.
`default_nettype none

module greedy_nearest_pair_assigner
    import gnpa_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_payload
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PICK  = 6'b001000,
        S_RD    = 6'b010000,
        S_LOAD  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [W_CNT_BITS-1:0]  wcnt_reg, wcnt_next;
    logic [R_CNT_BITS-1:0]  rcnt_reg, rcnt_next;
    logic [W_CNT_BITS-1:0]  rounds_reg, rounds_next;
    logic [W_IDX_BITS-1:0]  w_reg, w_next;
    logic [R_IDX_BITS-1:0]  r_reg, r_next;
    logic [MAX_WORKERS-1:0]   wdone_reg, wdone_next;
    logic [MAX_RESOURCES-1:0] rtaken_reg, rtaken_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_payload_reg, m_payload_next;

    logic      s_fire;
    logic      w_full, r_full;
    logic      w_last, r_last;
    logic      out_free;
    logic      pick_clear;
    logic      pick_busy;
    probe_t    probe;
    best_t     best;
    point_t    load_pt;
    point_t    worker_pt, resource_pt;
    logic      wram_we, rram_we, aram_we;
    logic [W_IDX_BITS-1:0] wram_raddr;
    logic [R_IDX_BITS-1:0] aram_rdata;
    logic [W_CNT_BITS-1:0] min_cnt;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign w_full   = (wcnt_reg == W_CNT_BITS'(MAX_WORKERS));
    assign r_full   = (rcnt_reg == R_CNT_BITS'(MAX_RESOURCES));
    assign load_pt.x = COORD_BITS'(s_payload.x_coord);
    assign load_pt.y = COORD_BITS'(s_payload.y_coord);
    assign wram_we  = s_fire && (s_payload.opcode == OP_LOAD_WORKER) && !w_full;
    assign rram_we  = s_fire && (s_payload.opcode == OP_LOAD_RESOURCE) && !r_full;
    assign aram_we  = (state_reg == S_PICK) && best.found;
    assign w_last   = (W_CNT_BITS'(w_reg) + W_CNT_BITS'(1)) == wcnt_reg;
    assign r_last   = (R_CNT_BITS'(r_reg) + R_CNT_BITS'(1)) == rcnt_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign min_cnt  = (W_CNT_BITS'(rcnt_reg) < wcnt_reg) ? W_CNT_BITS'(rcnt_reg)
                                                          : wcnt_reg;

    // The worker memory is shared by loading, scanning and nothing else; during
    // result output only the assignment memory, read at the same worker index, is used.
    assign wram_raddr = w_reg;

    assign probe.valid = (state_reg == S_SCAN) && !wdone_reg[w_reg] && !rtaken_reg[r_reg];
    assign probe.w     = w_reg;
    assign probe.r     = r_reg;

    gnpa_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_WORKERS)
    ) u_worker_ram (
        .aclk  (aclk),
        .we    (wram_we),
        .waddr (W_IDX_BITS'(wcnt_reg)),
        .wdata (load_pt),
        .raddr (wram_raddr),
        .rdata (worker_pt)
    );

    gnpa_ram #(
        .WIDTH (POINT_BITS),
        .DEPTH (MAX_RESOURCES)
    ) u_resource_ram (
        .aclk  (aclk),
        .we    (rram_we),
        .waddr (R_IDX_BITS'(rcnt_reg)),
        .wdata (load_pt),
        .raddr (r_reg),
        .rdata (resource_pt)
    );

    gnpa_ram #(
        .WIDTH (R_IDX_BITS),
        .DEPTH (MAX_WORKERS)
    ) u_assign_ram (
        .aclk  (aclk),
        .we    (aram_we),
        .waddr (best.w),
        .wdata (best.r),
        .raddr (w_reg),
        .rdata (aram_rdata)
    );

    gnpa_pick u_pick (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clear       (pick_clear),
        .probe       (probe),
        .worker_pt   (worker_pt),
        .resource_pt (resource_pt),
        .best        (best),
        .busy        (pick_busy)
    );

    always_comb begin
        state_next     = state_reg;
        wcnt_next      = wcnt_reg;
        rcnt_next      = rcnt_reg;
        rounds_next    = rounds_reg;
        w_next         = w_reg;
        r_next         = r_reg;
        wdone_next     = wdone_reg;
        rtaken_next    = rtaken_reg;
        pick_clear     = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;

        case (state_reg)
            S_IDLE: begin
                w_next = '0;
                r_next = '0;
                if (wram_we) begin
                    wcnt_next = wcnt_reg + W_CNT_BITS'(1);
                end
                if (rram_we) begin
                    rcnt_next = rcnt_reg + R_CNT_BITS'(1);
                end
                if (s_fire && s_payload.opcode == OP_RUN) begin
                    wdone_next  = '0;
                    rtaken_next = '0;
                    pick_clear  = 1'b1;
                    rounds_next = min_cnt;
                    if (wcnt_reg == '0) begin
                        rcnt_next = '0;
                    end else if (min_cnt == '0) begin
                        state_next = S_RD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_last) begin
                    r_next = '0;
                    if (w_last) begin
                        w_next     = '0;
                        state_next = S_DRAIN;
                    end else begin
                        w_next = w_reg + W_IDX_BITS'(1);
                    end
                end else begin
                    r_next = r_reg + R_IDX_BITS'(1);
                end
            end
            S_DRAIN: begin
                if (!pick_busy) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                pick_clear = 1'b1;
                if (best.found) begin
                    wdone_next[best.w]  = 1'b1;
                    rtaken_next[best.r] = 1'b1;
                end
                rounds_next = rounds_reg - W_CNT_BITS'(1);
                if (!best.found || rounds_reg == W_CNT_BITS'(1)) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_RD: begin
                // The assignment memory is addressed by w_reg during this cycle.
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    m_valid_next                  = 1'b1;
                    m_payload_next.worker_index   = OUT_IDX_BITS'(w_reg);
                    m_payload_next.has_resource   = wdone_reg[w_reg];
                    m_payload_next.resource_index = wdone_reg[w_reg]
                                                    ? OUT_IDX_BITS'(aram_rdata) : '0;
                    m_payload_next.last           = w_last;
                    if (w_last) begin
                        wcnt_next  = '0;
                        rcnt_next  = '0;
                        w_next     = '0;
                        state_next = S_IDLE;
                    end else begin
                        w_next     = w_reg + W_IDX_BITS'(1);
                        state_next = S_RD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            wcnt_reg    <= '0;
            rcnt_reg    <= '0;
            rounds_reg  <= '0;
            w_reg       <= '0;
            r_reg       <= '0;
            wdone_reg   <= '0;
            rtaken_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wcnt_reg    <= wcnt_next;
            rcnt_reg    <= rcnt_next;
            rounds_reg  <= rounds_next;
            w_reg       <= w_next;
            r_reg       <= r_next;
            wdone_reg   <= wdone_next;
            rtaken_reg  <= rtaken_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_payload_reg <= m_payload_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Every pick takes one worker and one resource together.
    a_pairs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(wdone_reg) == $countones(rtaken_reg))
        else $error("worker and resource usage counts differ");

    // No pair may still be in the distance pipeline while new items are taken.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pick_busy)
        else $error("distance pipeline busy while idle");

    a_counts_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (wcnt_reg <= W_CNT_BITS'(MAX_WORKERS)) && (rcnt_reg <= R_CNT_BITS'(MAX_RESOURCES)))
        else $error("point count beyond capacity");

    // A pick is only made from a completed scan.
    a_pick_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PICK) |-> $past(state_reg == S_DRAIN))
        else $error("pick without a drained scan");

endmodule

`default_nettype wire

### rtl/gnpa_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module gnpa_ram #(
    parameter  int WIDTH     = 8,
    parameter  int DEPTH     = 16,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  aclk,
    input  wire logic                  we,
    input  wire logic [ADDR_BITS-1:0]  waddr,
    input  wire logic [WIDTH-1:0]      wdata,
    input  wire logic [ADDR_BITS-1:0]  raddr,
    output logic      [WIDTH-1:0]      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/gnpa_pick.sv
// Distance pipeline and running minimum over the candidate pairs of one round.
`default_nettype none

module gnpa_pick
    import gnpa_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   clear,
    input  wire probe_t probe,
    input  wire point_t worker_pt,
    input  wire point_t resource_pt,
    output best_t       best,
    output logic        busy
);

    probe_t                 tag0_reg;
    probe_t                 tag1_reg;
    logic [DIST_BITS-1:0]   dist_reg;
    logic [DIST_BITS-1:0]   dist_next;
    logic [COORD_BITS-1:0]  dx;
    logic [COORD_BITS-1:0]  dy;
    logic                   found_reg;
    logic [DIST_BITS-1:0]   best_d_reg;
    logic [W_IDX_BITS-1:0]  best_w_reg;
    logic [R_IDX_BITS-1:0]  best_r_reg;
    logic                   take;

    always_comb begin
        dx = (worker_pt.x > resource_pt.x) ? worker_pt.x - resource_pt.x
                                           : resource_pt.x - worker_pt.x;
        dy = (worker_pt.y > resource_pt.y) ? worker_pt.y - resource_pt.y
                                           : resource_pt.y - worker_pt.y;
        dist_next = DIST_BITS'(dx) + DIST_BITS'(dy);
    end

    // Pairs arrive in worker-major order, so a strict compare keeps the
    // lowest worker index, then the lowest resource index, on a tie.
    assign take = tag1_reg.valid && (!found_reg || dist_reg < best_d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag0_reg  <= '0;
            tag1_reg  <= '0;
            found_reg <= 1'b0;
        end else begin
            tag0_reg <= probe;
            tag1_reg <= tag0_reg;
            if (clear) begin
                found_reg <= 1'b0;
            end else if (take) begin
                found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        dist_reg <= dist_next;
        if (take) begin
            best_d_reg <= dist_reg;
            best_w_reg <= tag1_reg.w;
            best_r_reg <= tag1_reg.r;
        end
    end

    assign best.found = found_reg;
    assign best.w     = best_w_reg;
    assign best.r     = best_r_reg;
    assign busy       = tag0_reg.valid | tag1_reg.valid;

endmodule

`default_nettype wire

### tb/nearest_pair_checker.sv
// Checker for the greedy nearest-pair assigner: predicts each run's results and compares them.
module nearest_pair_checker
    import gnpa_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_payload,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_payload,
    output int        mismatch_count,
    output int        results_awaited
);

    point_t    worker_pts   [MAX_WORKERS];
    point_t    resource_pts [MAX_RESOURCES];
    int        workers_loaded   = 0;
    int        resources_loaded = 0;
    int        errors           = 0;
    out_item_t assignment_q [$];

    // Greedy matching over the points loaded since the last run. One result per worker
    // is queued, and both stores are emptied afterwards.
    function automatic void predict_assignment();
        logic [3:0] chosen  [MAX_WORKERS];
        logic       matched [MAX_WORKERS];
        logic       taken   [MAX_RESOURCES];
        logic       found;
        int         rounds, best_d, best_w, best_r, dx, dy, d;
        out_item_t  item;

        for (int w = 0; w < MAX_WORKERS; w++) begin
            matched[w] = 1'b0;
            chosen[w]  = '0;
        end
        for (int r = 0; r < MAX_RESOURCES; r++) begin
            taken[r] = 1'b0;
        end
        rounds = (workers_loaded < resources_loaded) ? workers_loaded : resources_loaded;

        for (int k = 0; k < rounds; k++) begin
            found  = 1'b0;
            best_d = 0;
            best_w = 0;
            best_r = 0;
            // Strict less-than keeps the first pair in scan order, so ties favor
            // the lower worker index and then the lower resource index.
            for (int w = 0; w < workers_loaded; w++) begin
                if (!matched[w]) begin
                    for (int r = 0; r < resources_loaded; r++) begin
                        if (!taken[r]) begin
                            dx = int'(worker_pts[w].x) - int'(resource_pts[r].x);
                            dy = int'(worker_pts[w].y) - int'(resource_pts[r].y);
                            d  = (dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy);
                            if (!found || d < best_d) begin
                                found  = 1'b1;
                                best_d = d;
                                best_w = w;
                                best_r = r;
                            end
                        end
                    end
                end
            end
            if (!found) break;
            matched[best_w] = 1'b1;
            chosen[best_w]  = best_r[3:0];
            taken[best_r]   = 1'b1;
        end

        for (int w = 0; w < workers_loaded; w++) begin
            item.worker_index   = w[3:0];
            item.resource_index = matched[w] ? chosen[w] : 4'd0;
            item.has_resource   = matched[w];
            item.last           = (w == workers_loaded - 1);
            assignment_q.insert(assignment_q.size(), item);
        end
        workers_loaded   = 0;
        resources_loaded = 0;
    endfunction

    always @(posedge aclk) begin : watch_channels
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                case (opcode_t'(s_payload.opcode))
                    OP_LOAD_WORKER: begin
                        if (workers_loaded < MAX_WORKERS) begin
                            worker_pts[workers_loaded].x = s_payload.x_coord;
                            worker_pts[workers_loaded].y = s_payload.y_coord;
                            workers_loaded++;
                        end
                    end
                    OP_LOAD_RESOURCE: begin
                        if (resources_loaded < MAX_RESOURCES) begin
                            resource_pts[resources_loaded].x = s_payload.x_coord;
                            resource_pts[resources_loaded].y = s_payload.y_coord;
                            resources_loaded++;
                        end
                    end
                    OP_RUN: begin
                        predict_assignment();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (assignment_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer, expected none, got worker %0d",
                             $time, m_payload.worker_index,
                             " resource %0d has_resource %0b last %0b",
                             m_payload.resource_index, m_payload.has_resource,
                             m_payload.last);
                end else begin
                    want = assignment_q.pop_front();
                    if (m_payload.worker_index !== want.worker_index ||
                        m_payload.resource_index !== want.resource_index ||
                        m_payload.has_resource !== want.has_resource ||
                        m_payload.last !== want.last) begin
                        errors++;
                        $display("%0t: result mismatch, expected worker %0d resource %0d",
                                 $time, want.worker_index, want.resource_index,
                                 " has_resource %0b last %0b, got worker %0d resource %0d",
                                 want.has_resource, want.last, m_payload.worker_index,
                                 m_payload.resource_index,
                                 " has_resource %0b last %0b",
                                 m_payload.has_resource, m_payload.last);
                    end
                end
            end
        end
        mismatch_count  <= errors;
        results_awaited <= assignment_q.size();
    end

endmodule

### tb/greedy_nearest_pair_assigner_test.sv
// Testbench top for the greedy nearest-pair assigner: clock, reset, stimulus and verdict.
module greedy_nearest_pair_assigner_test;
    import gnpa_pkg::*;

    localparam int RANDOM_ITEMS = 200;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 60;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;

    logic      hold_off         = 1'b0;
    int        mismatch_count;
    int        results_awaited;
    int        cycle_count      = 0;
    int        useful_items     = 0;
    int        workers_queued   = 0;
    int        resources_queued = 0;
    int        burst_left       = 1;
    int        big_runs         = 0;
    int        ready_mode       = 0;
    int        mode_left        = 0;
    int        tick             = 0;

    always #5 aclk = ~aclk;

    greedy_nearest_pair_assigner u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    nearest_pair_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .mismatch_count  (mismatch_count),
        .results_awaited (results_awaited)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver switches between always ready, random, mostly stalled and a fixed duty cycle.
    always @(posedge aclk) begin : receiver_pattern
        logic ready_now;
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(10, 150);
        end else begin
            mode_left <= mode_left - 1;
        end
        tick <= tick + 1;
        case (ready_mode)
            0:       ready_now = 1'b1;
            1:       ready_now = ($urandom_range(0, 1) == 1);
            2:       ready_now = ($urandom_range(0, 4) == 0);
            default: ready_now = (tick % 8 < 3);
        endcase
        m_ready <= ready_now && !hold_off;
    end

    // One long hold-off on the result side, so that a run fills the output and stalls the input.
    initial begin
        wait (useful_items >= HOLD_AFTER);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    function automatic in_item_t make_item(opcode_t op, logic [9:0] x, logic [9:0] y);
        in_item_t it;
        it.opcode  = op;
        it.x_coord = x;
        it.y_coord = y;
        return it;
    endfunction

    // Clustered points lie in a tiny box so that equal distances are common.
    function automatic logic [9:0] pick_coord(bit clustered);
        if (clustered) return 10'(500 + $urandom_range(0, 3));
        case ($urandom_range(0, 7))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 19))
            0:       return 0;
            1, 2:    return $urandom_range(6, 12);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // Holds the item until its transfer, then keeps the burst going or opens a gap.
    task automatic send(in_item_t it);
        int gap;
        s_payload <= it;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        case (opcode_t'(it.opcode))
            OP_LOAD_WORKER: begin
                if (workers_queued < MAX_WORKERS) begin
                    workers_queued++;
                    useful_items++;
                end
            end
            OP_LOAD_RESOURCE: begin
                if (resources_queued < MAX_RESOURCES) begin
                    resources_queued++;
                    useful_items++;
                end
            end
            OP_RUN: begin
                workers_queued   = 0;
                resources_queued = 0;
                useful_items++;
            end
            default: ;
        endcase
        burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Worker and resource loads in random interleaving with a stray no-op now and then,
    // closed by a run.
    task automatic send_point_set(int n_workers, int n_resources, bit clustered);
        int w_left;
        int r_left;
        w_left = n_workers;
        r_left = n_resources;
        while (w_left + r_left > 0) begin
            if ($urandom_range(0, 11) == 0) begin
                send(make_item(OP_NONE, pick_coord(0), pick_coord(0)));
            end
            if (r_left == 0 || (w_left > 0 && $urandom_range(0, 1) == 0)) begin
                send(make_item(OP_LOAD_WORKER, pick_coord(clustered), pick_coord(clustered)));
                w_left--;
            end else begin
                send(make_item(OP_LOAD_RESOURCE, pick_coord(clustered), pick_coord(clustered)));
                r_left--;
            end
        end
        send(make_item(OP_RUN, pick_coord(0), pick_coord(0)));
    endtask

    initial begin
        int random_goal;
        int n_workers;
        int n_resources;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Run with nothing loaded, then the unused opcode.
        send(make_item(OP_RUN, 10'd0, 10'd0));
        send(make_item(OP_NONE, 10'd1023, 10'd1023));

        // Opposite corners: each worker must take the resource on its own corner.
        send(make_item(OP_LOAD_WORKER, 10'd0, 10'd0));
        send(make_item(OP_LOAD_WORKER, 10'd1023, 10'd1023));
        send(make_item(OP_LOAD_RESOURCE, 10'd1023, 10'd1023));
        send(make_item(OP_LOAD_RESOURCE, 10'd0, 10'd0));
        send(make_item(OP_RUN, 10'd1023, 10'd1023));

        // Four equal distances: the tie break decides the first pick.
        send(make_item(OP_LOAD_WORKER, 10'd512, 10'd512));
        send(make_item(OP_LOAD_WORKER, 10'd512, 10'd512));
        send(make_item(OP_LOAD_RESOURCE, 10'd512, 10'd513));
        send(make_item(OP_LOAD_RESOURCE, 10'd513, 10'd512));
        send(make_item(OP_RUN, 10'd0, 10'd0));

        // Workers without any resource.
        send(make_item(OP_LOAD_WORKER, 10'd0, 10'd1023));
        send(make_item(OP_LOAD_WORKER, 10'd1023, 10'd0));
        send(make_item(OP_RUN, 10'd0, 10'd0));

        // Resources without workers are discarded by the run; the next worker finds none.
        send(make_item(OP_LOAD_RESOURCE, 10'd7, 10'd7));
        send(make_item(OP_RUN, 10'd0, 10'd0));
        send(make_item(OP_LOAD_WORKER, 10'd7, 10'd7));
        send(make_item(OP_RUN, 10'd0, 10'd0));

        random_goal = useful_items + RANDOM_ITEMS;

        // Both stores overfilled once so that the extra loads are dropped.
        send_point_set(MAX_WORKERS + 1, MAX_RESOURCES + 1, 1'b0);
        big_runs = 1;

        while (useful_items < random_goal) begin
            if ($urandom_range(0, 4) != 0) begin
                if (big_runs < 4 && $urandom_range(0, 24) == 0) begin
                    n_workers   = $urandom_range(13, MAX_WORKERS + 2);
                    n_resources = $urandom_range(13, MAX_RESOURCES + 2);
                    big_runs++;
                end else begin
                    n_workers   = pick_size();
                    n_resources = pick_size();
                end
                send_point_set(n_workers, n_resources, $urandom_range(0, 3) == 0);
            end else begin
                // Loose items with any opcode, which may leave loads waiting for a later run.
                repeat ($urandom_range(1, 8)) begin
                    send(make_item(opcode_t'($urandom_range(0, 3)), pick_coord(0),
                                   pick_coord(0)));
                end
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (results_awaited != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
